// ===== rtl/core/p80_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_pkg
// Shared constants, types and round functions of the PRESENT-80 core.
// ----------------------------------------------------------------------------
package p80_pkg;

  localparam int unsigned RoundsDefault = 31;
  localparam int unsigned BlockW        = 64;
  localparam int unsigned KeyW          = 80;
  localparam int unsigned CntW          = 5;

  typedef enum logic [0:0] {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  // Side-band that travels with each block through the round stages.
  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } stage_ctl_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;  4'h1: y = 4'h5;  4'h2: y = 4'h6;  4'h3: y = 4'hB;
      4'h4: y = 4'h9;  4'h5: y = 4'h0;  4'h6: y = 4'hA;  4'h7: y = 4'hD;
      4'h8: y = 4'h3;  4'h9: y = 4'hE;  4'hA: y = 4'hF;  4'hB: y = 4'h8;
      4'hC: y = 4'h4;  4'hD: y = 4'h7;  4'hE: y = 4'h1;  default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h5;  4'h1: y = 4'hE;  4'h2: y = 4'hF;  4'h3: y = 4'h8;
      4'h4: y = 4'hC;  4'h5: y = 4'h1;  4'h6: y = 4'h2;  4'h7: y = 4'hD;
      4'h8: y = 4'hB;  4'h9: y = 4'h4;  4'hA: y = 4'h6;  4'hB: y = 4'h3;
      4'hC: y = 4'h0;  4'hD: y = 4'h7;  4'hE: y = 4'h9;  default: y = 4'hA;
    endcase
    return y;
  endfunction

  function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                  input logic [BlockW-1:0] rk);
    logic [BlockW-1:0] t;
    logic [BlockW-1:0] r;
    t = s ^ rk;
    for (int n = 0; n < 16; n++) t[4*n +: 4] = sbox_fwd(t[4*n +: 4]);
    r = '0;
    r[63] = t[63];
    for (int i = 0; i < 63; i++) r[(i * 16) % 63] = t[i];
    return r;
  endfunction

  function automatic logic [BlockW-1:0] dec_round(input logic [BlockW-1:0] s,
                                                  input logic [BlockW-1:0] rk);
    logic [BlockW-1:0] t;
    logic [BlockW-1:0] r;
    t = s ^ rk;
    r = '0;
    r[63] = t[63];
    for (int i = 0; i < 63; i++) r[i] = t[(i * 16) % 63];
    for (int n = 0; n < 16; n++) r[4*n +: 4] = sbox_inv(r[4*n +: 4]);
    return r;
  endfunction

  // One step of the key schedule; cnt is the round counter.
  function automatic logic [KeyW-1:0] key_next(input logic [KeyW-1:0] k,
                                               input logic [CntW-1:0] cnt);
    logic [KeyW-1:0] n;
    n = {k[18:0], k[79:19]};
    n[79:76] = sbox_fwd(n[79:76]);
    n[19:15] = n[19:15] ^ cnt;
    return n;
  endfunction

endpackage

// ===== rtl/core/p80_key_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_key_sched
// Key registers and round key table, expanded one step per cycle after a write.
// ----------------------------------------------------------------------------
module p80_key_sched
  import p80_pkg::*;
#(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_i,
  input  logic                    wr_idx_i,
  input  logic [63:0]             wr_data_i,
  output logic [Rounds:0][BlockW-1:0] rk_o
);

  logic [KeyW-1:0] key_q;
  logic [Rounds:0][KeyW-1:0] ks_q, ks_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (wr_i) begin
      if (wr_idx_i == REG_KEY_HIGH) key_q[79:16] <= wr_data_i;
      else key_q[15:0] <= wr_data_i[15:0];
    end
  end

  // Each entry is registered from one key step applied to the entry before it, so the table settles entry by entry.
  always_comb begin
    ks_d[0] = key_q;
    for (int r = 1; r <= Rounds; r++) ks_d[r] = key_next(ks_q[r-1], CntW'(r));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q <= '0;
    end else begin
      ks_q <= ks_d;
    end
  end

  always_comb begin
    for (int r = 0; r <= Rounds; r++) rk_o[r] = ks_q[r][79:16];
  end

endmodule

// ===== rtl/core/p80_round_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_round_pipe
// One register stage per round, shared by encrypt and decrypt paths.
// ----------------------------------------------------------------------------
module p80_round_pipe
  import p80_pkg::*;
#(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  stage_ctl_t                  in_ctl_i,
  input  logic [BlockW-1:0]           in_data_i,
  input  logic [Rounds:0][BlockW-1:0] rk_i,
  output stage_ctl_t                  out_ctl_o,
  output logic [BlockW-1:0]           out_data_o
);

  stage_ctl_t [Rounds:0]             ctl_q;
  logic       [Rounds:0][BlockW-1:0] dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Rounds; s++) ctl_q[s] <= '{valid: 1'b0, cmd: CMD_ENC};
    end else if (adv_i) begin
      ctl_q[0] <= in_ctl_i;
      for (int s = 1; s <= Rounds; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dat_q[0] <= in_data_i;
      for (int s = 1; s <= Rounds; s++) begin
        if (ctl_q[s-1].cmd == CMD_DEC) dat_q[s] <= dec_round(dat_q[s-1], rk_i[Rounds-s+1]);
        else dat_q[s] <= enc_round(dat_q[s-1], rk_i[s-1]);
      end
    end
  end

  assign out_ctl_o  = ctl_q[Rounds];
  assign out_data_o = dat_q[Rounds] ^
                      ((ctl_q[Rounds].cmd == CMD_DEC) ? rk_i[0] : rk_i[Rounds]);

endmodule

// ===== rtl/core/present80_block_cipher_core.sv =====
`timescale 1ns / 1ps
// Pipeline: 31 round stages, an input stage and the output register; one block
// per cycle while neither the output stall nor the key settling holds the input.
// The whole pipeline holds when the output register is full and stalled.
// Reset clears the key to zero and all valid bits; the input stalls after
// reset or after a key write while the round keys settle.
// ----------------------------------------------------------------------------
// present80_block_cipher_core
// Pipelined PRESENT-80 encrypt/decrypt core with configurable key.
// ----------------------------------------------------------------------------
module present80_block_cipher_core
  import p80_pkg::*;
#(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [63:0]       cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [BlockW-1:0] data_block_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BlockW-1:0] result_block_o
);

  logic [Rounds:0][BlockW-1:0] rk;
  logic       adv;
  logic       cfg_hit;
  stage_ctl_t in_ctl, pipe_ctl;
  logic [BlockW-1:0] pipe_data;
  logic       out_valid_q;
  logic [BlockW-1:0] out_data_q;
  logic [CntW-1:0]   settle_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i && (cfg_index_i[63:1] == '0);

  p80_key_sched #(.Rounds(Rounds)) u_key (
    .clk_i, .rst_ni,
    .wr_i      (cfg_hit),
    .wr_idx_i  (cfg_index_i[0]),
    .wr_data_i (cfg_data_i),
    .rk_o      (rk)
  );

  // Hold the input until every round key reflects the current key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) settle_q <= CntW'(Rounds);
    else if (cfg_hit) settle_q <= CntW'(Rounds);
    else if (settle_q != '0) settle_q <= settle_q - CntW'(1);
  end

  // Advance unless a finished block sits stalled in the output register.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv || (settle_q != '0);
  assign in_ctl     = '{valid: in_valid_i && !in_stall_o, cmd: cmd_e'(cmd_i)};

  p80_round_pipe #(.Rounds(Rounds)) u_pipe (
    .clk_i, .rst_ni,
    .adv_i      (adv),
    .in_ctl_i   (in_ctl),
    .in_data_i  (data_block_i),
    .rk_i       (rk),
    .out_ctl_o  (pipe_ctl),
    .out_data_o (pipe_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= pipe_ctl.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_q <= pipe_data;
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_data_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled output beat changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q || (settle_q != '0))
    else $error("input stalled without a pending output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && pipe_ctl.valid |=> out_valid_q)
    else $error("pipeline beat dropped");
`endif

endmodule

// ===== tb/present80_block_cipher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_cipher_core_tb
// Drives blocks for encryption and decryption under several keys through
// the pipelined cipher core. Random gaps are inserted on both sides. Every
// result is compared with a software model of the cipher, in arrival order.
// ----------------------------------------------------------------------------
module present80_block_cipher_core_tb;
  import p80_pkg::*;

  localparam int unsigned NumRandom = 800;
  localparam int unsigned Latency   = 40;
  localparam int unsigned Watchdog  = 5000;

  class cipher_scoreboard;
    logic [63:0] key_hi;
    logic [15:0] key_lo;
    logic [63:0] pending_q[$];
    int unsigned errors;

    function new();
      key_hi = '0;
      key_lo = '0;
      errors = 0;
    endfunction

    function logic [3:0] sb(input logic [3:0] x, input bit inv);
      logic [3:0] fwd[16];
      logic [3:0] bwd[16];
      fwd = '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
              4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};
      bwd = '{4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
              4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA};
      return inv ? bwd[x] : fwd[x];
    endfunction

    function logic [63:0] cipher(input cmd_e op, input logic [63:0] blk);
      logic [63:0] rk[32];
      logic [79:0] k;
      logic [79:0] kn;
      logic [63:0] s;
      logic [63:0] t;
      k = {key_hi, key_lo};
      rk[0] = k[79:16];
      for (int r = 1; r <= 31; r++) begin
        kn = {k[18:0], k[79:19]};
        kn[79:76] = sb(kn[79:76], 1'b0);
        kn[19:15] = kn[19:15] ^ 5'(r);
        k = kn;
        rk[r] = k[79:16];
      end
      s = blk;
      if (op == CMD_ENC) begin
        for (int r = 0; r < 31; r++) begin
          s = s ^ rk[r];
          for (int n = 0; n < 16; n++) s[4*n +: 4] = sb(s[4*n +: 4], 1'b0);
          t = '0;
          t[63] = s[63];
          for (int i = 0; i < 63; i++) t[(i * 16) % 63] = s[i];
          s = t;
        end
        s = s ^ rk[31];
      end else begin
        for (int r = 31; r >= 1; r--) begin
          s = s ^ rk[r];
          t = '0;
          t[63] = s[63];
          for (int i = 0; i < 63; i++) t[i] = s[(i * 16) % 63];
          for (int n = 0; n < 16; n++) t[4*n +: 4] = sb(t[4*n +: 4], 1'b1);
          s = t;
        end
        s = s ^ rk[0];
      end
      return s;
    endfunction

    function void note_block(input cmd_e op, input logic [63:0] blk);
      pending_q.insert(pending_q.size(), cipher(op, blk));
    endfunction

    function void check_result(input logic [63:0] got);
      logic [63:0] exp_blk;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_blk = pending_q.pop_front();
        if (got !== exp_blk) begin
          $display("%0t: result_block expected %h actual %h", $time, exp_blk, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [63:0] data_block_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_block_o;

  cipher_scoreboard board = new();
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;
  int          max_gap = 16;

  always #1 clk_i = ~clk_i;

  present80_block_cipher_core dut (.*);

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) board.note_block(cmd_e'(cmd_i), data_block_i);
    if (out_valid_o && !out_stall_i) board.check_result(result_block_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random backpressure on the result side.
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = $urandom_range(0, max_gap);
      out_stall_i <= (gap != 0);
      repeat (gap) @(posedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= Watchdog && !timed_out) begin
      timed_out = 1'b1;
      $display("present80_block_cipher_core_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 64'(idx);
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_KEY_HIGH) board.key_hi = val;
    else board.key_lo = val[15:0];
  endtask

  task automatic send_block(input cmd_e op, input logic [63:0] blk, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, max_gap) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    data_block_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] blk;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (Latency) @(posedge clk_i);

    // Directed: reset key, extreme blocks, both operations.
    send_block(CMD_ENC, '0, 1'b0);
    send_block(CMD_ENC, '1, 1'b0);
    send_block(CMD_DEC, '0, 1'b0);
    send_block(CMD_DEC, '1, 1'b0);
    drain();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, 64'hFFFF);
    repeat (Latency) @(posedge clk_i);
    send_block(CMD_ENC, '0, 1'b0);
    send_block(CMD_ENC, '1, 1'b0);
    send_block(CMD_DEC, '0, 1'b0);
    send_block(CMD_DEC, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
    drain();
    // Upper bits of key_low are dropped, out-of-range index is ignored.
    write_reg(REG_KEY_LOW, 64'hDEAD_BEEF_0000_1234);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 64'd7;
    cfg_data_i  <= '0;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    repeat (Latency) @(posedge clk_i);
    send_block(CMD_ENC, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_block(CMD_DEC, 64'hFEDC_BA98_7654_3210, 1'b0);
    drain();

    // Random: eight key phases, burst traffic in phases 0, 3 and 6 and gapped traffic in the rest.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_HIGH, (ph == 7) ? 64'h0 : rand64());
      write_reg(REG_KEY_LOW, (ph == 7) ? 64'h0 : 64'($urandom_range(0, 16'hFFFF)));
      repeat (Latency) @(posedge clk_i);
      max_gap = (ph % 3 == 0) ? 0 : 16;
      for (int n = 0; n < NumRandom / 8; n++) begin
        blk = rand64();
        send_block(cmd_e'($urandom_range(0, 1)), blk, 1'b1);
      end
      drain();
      max_gap = 16;
    end

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("present80_block_cipher_core_tb: done, clean");
    end else begin
      $display("present80_block_cipher_core_tb: done, errors");
    end
    $finish;
  end

endmodule
